### hdl/fmm_pkg.sv
// ----------------------------------------------------------------------------
// fmm_pkg
// shared types and constants of the min/max tracking queue
// ----------------------------------------------------------------------------
package fmm_pkg;

    localparam int FMM_DEPTH      = 16;
    localparam int FMM_DATA_WIDTH = 32;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } fmm_status_t;

    typedef struct packed {
        logic push;
        logic pop;
    } fmm_cell_ctrl_t;

endpackage

### hdl/fmm_cmd_if.sv
// ----------------------------------------------------------------------------
// fmm_cmd_if
// command channel: opcode and value to append
// ----------------------------------------------------------------------------
interface fmm_cmd_if
    import fmm_pkg::*;
#(
    parameter int DATA_WIDTH = FMM_DATA_WIDTH
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   opcode;
    logic signed [DATA_WIDTH-1:0] push_value;

    modport source (output valid, output opcode, output push_value, input ready);
    modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

### hdl/fmm_rsp_if.sv
// ----------------------------------------------------------------------------
// fmm_rsp_if
// result channel: popped value, front, min, max, count, empty flag, status
// ----------------------------------------------------------------------------
interface fmm_rsp_if
    import fmm_pkg::*;
#(
    parameter int DATA_WIDTH  = FMM_DATA_WIDTH,
    parameter int COUNT_WIDTH = $clog2(FMM_DEPTH + 1)
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] popped_value;
    logic signed [DATA_WIDTH-1:0] front_value;
    logic signed [DATA_WIDTH-1:0] min_value;
    logic signed [DATA_WIDTH-1:0] max_value;
    logic [COUNT_WIDTH-1:0]       fill_count;
    logic                         is_empty;
    logic [1:0]                   status;

    modport source (
        output valid, output popped_value, output front_value, output min_value,
        output max_value, output fill_count, output is_empty, output status,
        input ready
    );
    modport sink (
        input valid, input popped_value, input front_value, input min_value,
        input max_value, input fill_count, input is_empty, input status,
        output ready
    );
endinterface

### hdl/fmm_cell.sv
// ----------------------------------------------------------------------------
// fmm_cell
// one queue slot: holds a word, shifts toward the front on pop, and folds
// its word into the running min/max handed along the chain
// ----------------------------------------------------------------------------
module fmm_cell
    import fmm_pkg::*;
#(
    parameter int INDEX       = 0,
    parameter int DATA_WIDTH  = FMM_DATA_WIDTH,
    parameter int COUNT_WIDTH = $clog2(FMM_DEPTH + 1)
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  fmm_cell_ctrl_t               ctrl,
    input  logic [COUNT_WIDTH-1:0]       count,
    input  logic [COUNT_WIDTH-1:0]       count_now,
    input  logic signed [DATA_WIDTH-1:0] push_value,
    input  logic signed [DATA_WIDTH-1:0] next_data,
    input  logic signed [DATA_WIDTH-1:0] lo_in,
    input  logic signed [DATA_WIDTH-1:0] hi_in,
    input  logic                         seen_in,
    output logic signed [DATA_WIDTH-1:0] data,
    output logic signed [DATA_WIDTH-1:0] lo_out,
    output logic signed [DATA_WIDTH-1:0] hi_out,
    output logic                         seen_out
);

    logic signed [DATA_WIDTH-1:0] data_reg;
    logic signed [DATA_WIDTH-1:0] lo_reg;
    logic signed [DATA_WIDTH-1:0] lo_next;
    logic signed [DATA_WIDTH-1:0] hi_reg;
    logic signed [DATA_WIDTH-1:0] hi_next;
    logic                         seen_reg;
    logic                         occupied;

    assign occupied = (COUNT_WIDTH'(INDEX) < count_now);

    always_comb
    begin
        lo_next = lo_in;
        hi_next = hi_in;
        if (occupied)
        begin
            if (!seen_in || data_reg < lo_in)
            begin
                lo_next = data_reg;
            end
            if (!seen_in || data_reg > hi_in)
            begin
                hi_next = data_reg;
            end
        end
    end

    // word storage
    always_ff @(posedge clk)
    begin
        if (ctrl.pop)
        begin
            data_reg <= next_data;
        end
        else if (ctrl.push && count == COUNT_WIDTH'(INDEX))
        begin
            data_reg <= push_value;
        end
    end

    // min/max wavefront
    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
        end
        else
        begin
            seen_reg <= seen_in | occupied;
        end
    end

    assign data     = data_reg;
    assign lo_out   = lo_reg;
    assign hi_out   = hi_reg;
    assign seen_out = seen_reg;

endmodule

### hdl/fifo_min_max_tracker.sv
// ----------------------------------------------------------------------------
// fifo_min_max_tracker
// bounded fifo of signed words reporting front, min and max after each beat
//
//   channel | dir | beat contents
//   --------+-----+--------------------------------------------------------
//   cmd     | in  | opcode, push_value
//   rsp     | out | popped_value, front_value, min_value, max_value,
//           |     | fill_count, is_empty, status
//
// the result of a command beat is set by the min/max wavefront passing one
// cell per cycle down the chain of DEPTH cells
// cmd ready is high only while no command is in flight
// a result held in the output register does not block the next command; the
// scan waits at its end until the output register is free
// reset empties the queue; stored words need no clearing
// ----------------------------------------------------------------------------
module fifo_min_max_tracker
    import fmm_pkg::*;
#(
    parameter int DEPTH      = FMM_DEPTH,
    parameter int DATA_WIDTH = FMM_DATA_WIDTH
)
(
    input  logic clk,
    input  logic rst_n,
    fmm_cmd_if.sink   cmd,
    fmm_rsp_if.source rsp
);

    localparam int COUNT_WIDTH = $clog2(DEPTH + 1);
    localparam int CNT_WIDTH   = $clog2(DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t                       state_reg;
    logic [CNT_WIDTH-1:0]         scan_cnt_reg;
    logic [COUNT_WIDTH-1:0]       count_reg;
    logic [COUNT_WIDTH-1:0]       count_next;
    logic signed [DATA_WIDTH-1:0] popped_reg;
    fmm_status_t                  status_reg;
    fmm_status_t                  status_next;

    logic                         rsp_valid_reg;
    logic signed [DATA_WIDTH-1:0] rsp_popped_reg;
    logic signed [DATA_WIDTH-1:0] rsp_front_reg;
    logic signed [DATA_WIDTH-1:0] rsp_min_reg;
    logic signed [DATA_WIDTH-1:0] rsp_max_reg;
    logic [COUNT_WIDTH-1:0]       rsp_count_reg;
    logic                         rsp_empty_reg;
    fmm_status_t                  rsp_status_reg;

    logic                         accept;
    logic                         push_ok;
    logic                         pop_ok;
    logic                         finish;
    fmm_cell_ctrl_t               ctrl;

    logic signed [DATA_WIDTH-1:0] data_w [DEPTH];
    logic signed [DATA_WIDTH-1:0] lo_w   [DEPTH];
    logic signed [DATA_WIDTH-1:0] hi_w   [DEPTH];
    logic                         seen_w [DEPTH];

    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;

    assign push_ok = accept && (cmd.opcode == OP_PUSH) && (count_reg != COUNT_WIDTH'(DEPTH));
    assign pop_ok  = accept && (cmd.opcode == OP_POP) && (count_reg != '0);

    assign ctrl.push = push_ok;
    assign ctrl.pop  = pop_ok;

    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_OK;
        priority if (cmd.opcode == OP_PUSH)
        begin
            if (count_reg == COUNT_WIDTH'(DEPTH))
            begin
                status_next = ST_PUSH_FULL;
            end
            else
            begin
                count_next = count_reg + COUNT_WIDTH'(1);
            end
        end
        else if (cmd.opcode == OP_POP)
        begin
            if (count_reg == '0)
            begin
                status_next = ST_POP_EMPTY;
            end
            else
            begin
                count_next = count_reg - COUNT_WIDTH'(1);
            end
        end
        else
        begin
            status_next = ST_OK;
        end
    end

    assign finish = (state_reg == S_SCAN) && (scan_cnt_reg == '0)
                    && (!rsp_valid_reg || rsp.ready);

    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            logic signed [DATA_WIDTH-1:0] next_data;
            logic signed [DATA_WIDTH-1:0] lo_in;
            logic signed [DATA_WIDTH-1:0] hi_in;
            logic                         seen_in;

            if (i == DEPTH - 1)
            begin : g_last
                assign next_data = '0;
            end
            else
            begin : g_mid
                assign next_data = data_w[i+1];
            end

            if (i == 0)
            begin : g_first
                assign lo_in   = '0;
                assign hi_in   = '0;
                assign seen_in = 1'b0;
            end
            else
            begin : g_rest
                assign lo_in   = lo_w[i-1];
                assign hi_in   = hi_w[i-1];
                assign seen_in = seen_w[i-1];
            end

            fmm_cell #(
                .INDEX       (i),
                .DATA_WIDTH  (DATA_WIDTH),
                .COUNT_WIDTH (COUNT_WIDTH)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .count      (count_reg),
                .count_now  (count_reg),
                .push_value (cmd.push_value),
                .next_data  (next_data),
                .lo_in      (lo_in),
                .hi_in      (hi_in),
                .seen_in    (seen_in),
                .data       (data_w[i]),
                .lo_out     (lo_w[i]),
                .hi_out     (hi_w[i]),
                .seen_out   (seen_w[i])
            );
        end
    endgenerate

    // control and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_cnt_reg  <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
        end
        else
        begin
            if (rsp_valid_reg && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        count_reg    <= count_next;
                        status_reg   <= status_next;
                        scan_cnt_reg <= CNT_WIDTH'(DEPTH);
                        state_reg    <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (scan_cnt_reg != '0)
                    begin
                        scan_cnt_reg <= scan_cnt_reg - CNT_WIDTH'(1);
                    end
                    else if (finish)
                    begin
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // beat payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            popped_reg <= pop_ok ? data_w[0] : '0;
        end
        if (finish)
        begin
            rsp_popped_reg <= popped_reg;
            rsp_front_reg  <= (count_reg != '0) ? data_w[0] : '0;
            rsp_min_reg    <= seen_w[DEPTH-1] ? lo_w[DEPTH-1] : '0;
            rsp_max_reg    <= seen_w[DEPTH-1] ? hi_w[DEPTH-1] : '0;
            rsp_count_reg  <= count_reg;
            rsp_empty_reg  <= (count_reg == '0);
            rsp_status_reg <= status_reg;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.popped_value = rsp_popped_reg;
    assign rsp.front_value  = rsp_front_reg;
    assign rsp.min_value    = rsp_min_reg;
    assign rsp.max_value    = rsp_max_reg;
    assign rsp.fill_count   = rsp_count_reg;
    assign rsp.is_empty     = rsp_empty_reg;
    assign rsp.status       = rsp_status_reg;

endmodule

### tb/sv/fmm_result_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fmm_result_check
// watches the command and result channels of the min/max tracking queue,
// keeps its own copy of the queue to work out the result of every accepted
// command, and compares each result beat field by field with the oldest
// expected result; failures are counted and handed to the testbench top
// ----------------------------------------------------------------------------
module fmm_result_check
    import fmm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    fmm_cmd_if   cmd,
    fmm_rsp_if   rsp,
    output int   fail_count,
    output int   pending
);

    localparam int CNT_W = $clog2(FMM_DEPTH + 1);

    typedef logic signed [FMM_DATA_WIDTH-1:0] word_t;

    typedef struct {
        word_t       popped;
        word_t       front;
        word_t       lo;
        word_t       hi;
        logic [CNT_W-1:0] count;
        logic        empty;
        fmm_status_t status;
    } fmm_result_t;

    word_t       stored_words [FMM_DEPTH];
    int          oldest_idx;
    int          stored_cnt;
    int          result_idx;
    fmm_result_t due_results [$];
    fmm_result_t due;

    function automatic fmm_result_t step_queue(logic [1:0] op, word_t value);
        fmm_result_t r;
        word_t       w;
        r.popped = '0;
        r.front  = '0;
        r.lo     = '0;
        r.hi     = '0;
        r.status = ST_OK;
        case (op)
            OP_PUSH:
            begin
                if (stored_cnt == FMM_DEPTH)
                begin
                    r.status = ST_PUSH_FULL;
                end
                else
                begin
                    stored_words[(oldest_idx + stored_cnt) % FMM_DEPTH] = value;
                    stored_cnt++;
                end
            end
            OP_POP:
            begin
                if (stored_cnt == 0)
                begin
                    r.status = ST_POP_EMPTY;
                end
                else
                begin
                    r.popped   = stored_words[oldest_idx];
                    oldest_idx = (oldest_idx + 1) % FMM_DEPTH;
                    stored_cnt--;
                end
            end
            default:
            begin
            end
        endcase
        if (stored_cnt > 0)
        begin
            r.front = stored_words[oldest_idx];
            r.lo    = r.front;
            r.hi    = r.front;
            for (int i = 1; i < stored_cnt; i++)
            begin
                w = stored_words[(oldest_idx + i) % FMM_DEPTH];
                if (w < r.lo)
                    r.lo = w;
                if (w > r.hi)
                    r.hi = w;
            end
        end
        r.count = CNT_W'(stored_cnt);
        r.empty = (stored_cnt == 0);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_idx = 0;
            stored_cnt = 0;
            result_idx = 0;
            due_results.delete();
            pending = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (due_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result %0d arrived with nothing expected", result_idx);
                end
                else
                begin
                    due = due_results.pop_front();
                    if (rsp.popped_value !== due.popped || rsp.front_value !== due.front ||
                        rsp.min_value !== due.lo || rsp.max_value !== due.hi ||
                        rsp.fill_count !== due.count || rsp.is_empty !== due.empty ||
                        rsp.status !== due.status)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("result %0d expected: pop %0d front %0d min %0d",
                                     result_idx, due.popped, due.front, due.lo,
                                     " max %0d cnt %0d e %0b st %0d",
                                     due.hi, due.count, due.empty, due.status);
                            $display("result %0d actual:   pop %0d front %0d min %0d",
                                     result_idx, rsp.popped_value, rsp.front_value,
                                     rsp.min_value,
                                     " max %0d cnt %0d e %0b st %0d",
                                     rsp.max_value, rsp.fill_count,
                                     rsp.is_empty, rsp.status);
                        end
                    end
                end
                result_idx++;
            end
            // result side first so a result never meets an expectation of the same edge
            if (cmd.valid && cmd.ready)
                due_results.insert(due_results.size(),
                                   step_queue(cmd.opcode, cmd.push_value));
            pending = due_results.size();
        end
    end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// testbench of the min/max tracking queue: drives directed and random
// command beats through four idling phases, with one long result hold-off
// and one mid-phase pause until all results are back; checking is done beside the
// block by fmm_result_check, this module gives the verdict
// ----------------------------------------------------------------------------
module tb;
    import fmm_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         HOLD_CYCLES = 400;
    localparam int         PHASE_BEATS = 170;

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    logic long_hold;
    int   hold_cnt;
    int   fill_est;
    logic filling;
    int   chk_fails;
    int   chk_pending;

    fmm_cmd_if cmd_ch ();
    fmm_rsp_if rsp_ch ();

    fifo_min_max_tracker u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    fmm_result_check u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_ch),
        .rsp        (rsp_ch),
        .fail_count (chk_fails),
        .pending    (chk_pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else if (long_hold)
        begin
            rsp_ch.ready <= 1'b0;
            hold_cnt = hold_cnt + 1;
        end
        else
        begin
            hold_cnt = 0;
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic signed [FMM_DATA_WIDTH-1:0] random_word();
        case ($urandom_range(9))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return '1;
            4, 5:    return $urandom_range(20) - 10;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_beat(input logic [1:0] op, input logic signed [FMM_DATA_WIDTH-1:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.opcode     <= op;
        cmd_ch.push_value <= v;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        if (op == OP_PUSH && fill_est < FMM_DEPTH)
            fill_est++;
        else if (op == OP_POP && fill_est > 0)
            fill_est--;
    endtask

    // sweeps the queue between empty and full so every fill level is reached
    task automatic send_random_beat();
        int          r;
        logic [1:0]  op;
        if (fill_est == FMM_DEPTH)
            filling = 1'b0;
        else if (fill_est == 0)
            filling = 1'b1;
        else if ($urandom_range(99) < 3)
            filling = ~filling;
        r = $urandom_range(99);
        if (r < 3)
            op = OP_UNUSED;
        else if (r < 12)
            op = OP_PEEK;
        else if (r < (filling ? 72 : 32))
            op = OP_PUSH;
        else
            op = OP_POP;
        send_beat(op, $urandom_range(3) == 0 ? random_word() : $urandom());
    endtask

    task automatic wait_results_done();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        wait (chk_pending == 0);
    endtask

    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.opcode     = OP_PEEK;
        cmd_ch.push_value = '0;
        rsp_ch.ready      = 1'b0;
        long_hold         = 1'b0;
        hold_cnt          = 0;
        fill_est          = 0;
        filling           = 1'b1;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue corner cases, then fill past full with extreme words
        send_beat(OP_POP, '0);
        send_beat(OP_PEEK, '1);
        send_beat(OP_UNUSED, 32'sh5a5a_a5a5);
        send_beat(OP_PUSH, 32'sh7fff_ffff);
        send_beat(OP_PUSH, 32'sh8000_0000);
        send_beat(OP_PUSH, '0);
        send_beat(OP_PUSH, '1);
        send_beat(OP_PUSH, 32'sh0000_0001);
        send_beat(OP_PEEK, '0);
        send_beat(OP_UNUSED, '1);
        for (int i = 5; i < FMM_DEPTH; i++)
            send_beat(OP_PUSH, random_word());
        send_beat(OP_PUSH, 32'sh1234_5678);
        send_beat(OP_POP, '1);
        send_beat(OP_POP, '0);
        wait_results_done();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 80;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 80;
                end
                default:
                begin
                    send_idle_pct  = 33;
                    recv_stall_pct = 33;
                end
            endcase
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                if (phase == 0 && n == PHASE_BEATS / 2)
                begin
                    fork
                        begin
                            long_hold = 1'b1;
                            wait (hold_cnt >= HOLD_CYCLES);
                            long_hold = 1'b0;
                        end
                        begin
                            repeat (6) send_random_beat();
                        end
                    join
                end
                if (phase == 2 && n == PHASE_BEATS / 2)
                    wait_results_done();
                send_random_beat();
            end
            wait_results_done();
        end

        repeat (FMM_DEPTH * 4) @(posedge clk);
        if (chk_fails == 0 && chk_pending == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb: FAIL");
        $finish;
    end

endmodule

### sim.f
hdl/fmm_pkg.sv
hdl/fmm_cmd_if.sv
hdl/fmm_rsp_if.sv
hdl/fmm_cell.sv
hdl/fifo_min_max_tracker.sv
tb/sv/fmm_result_check.sv
tb/sv/tb.sv
